### sv/msp_pkg.sv
// Shared types and fixed constants of the motor speed PID controller.
`default_nettype none

package msp_pkg;

  // Fixed field widths.
  localparam int COUNT_W    = 32;
  localparam int ELAPSED_W  = 16;
  localparam int SPEED_W    = 24;
  localparam int CMD_W      = 9;
  localparam int LEVEL_W    = 8;
  localparam int CPR_W      = 16;
  localparam int LIMIT_W    = 23;
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = 25;
  localparam int DERR_W     = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Fixed arithmetic constants.
  localparam int RPM_W      = 16;
  localparam logic [RPM_W-1:0] RPM_SCALE = 16'd60000;  // milliseconds per minute
  localparam int GAIN_FRAC  = 8;
  localparam int CAP_SHIFT  = 45;                      // integral clamp is 2^45

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENC_CPR        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd4;

  // Sequencer states.
  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_MUL_DEN   = 12'b0000_0000_0010,
    S_MUL_MAG   = 12'b0000_0000_0100,
    S_DIV_START = 12'b0000_0000_1000,
    S_DIV_WAIT  = 12'b0000_0001_0000,
    S_ERR       = 12'b0000_0010_0000,
    S_SUM       = 12'b0000_0100_0000,
    S_MUL_P     = 12'b0000_1000_0000,
    S_MUL_I     = 12'b0001_0000_0000,
    S_MUL_D     = 12'b0010_0000_0000,
    S_ACC       = 12'b0100_0000_0000,
    S_OUT       = 12'b1000_0000_0000
  } state_t;

endpackage

`default_nettype wire

### sv/msp_divider.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none

module msp_divider #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  logic             running;
  logic [CNT_W-1:0] step;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_next;

  // Bring in the next numerator bit and try to subtract the divisor.
  always_comb begin
    trial    = {rem, quot[NUM_W-1]};
    diff     = trial - {1'b0, den};
    fits     = (trial >= {1'b0, den});
    rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // Control: run for one step per quotient bit, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient register shifts the numerator out as quotient bits enter.
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= numer;
      rem  <= '0;
      den  <= denom;
    end else if (running) begin
      quot <= {quot[NUM_W-2:0], fits};
      rem  <= rem_next;
    end
  end

endmodule

`default_nettype wire

### sv/motor_speed_pid_controller_core.sv
// Top level of the motor speed PID controller: sequencer, shared multiplier and state.
`default_nettype none

// Each accepted item is one control tick. The block takes the encoder count, the elapsed
// milliseconds and the target speed, measures the speed as
// delta_count * 60000 * 2^SPEED_FRAC_BITS / (elapsed_ms * counts per revolution) in signed
// Q.SPEED_FRAC_BITS rpm (saturated to 24 bits), clamps the target to the speed limit and runs
// a PID loop with unsigned Q8.8 gains. The command is truncated toward zero, saturated to
// +/-255 and split into a PWM level and two direction lines that hold when the command is
// zero. A tick with a nonzero elapsed time passes through the divider, which produces one
// quotient bit per cycle (48 + SPEED_FRAC_BITS bits); a tick with zero elapsed time skips
// the divider. All products go through one 17 x 40 bit multiplier, used once per cycle.
// in_ready is high only while the sequencer is idle; a finished result waits in the output
// register while the next item is accepted. Configuration is written with cfg_write,
// cfg_index and cfg_data.

module motor_speed_pid_controller_core #(
  parameter int SPEED_FRAC_BITS = 8,
  parameter int SUM_WIDTH       = 40
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic        [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [msp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [msp_pkg::COUNT_W-1:0]     encoder_count,
  input  logic        [msp_pkg::ELAPSED_W-1:0]   elapsed_ms,
  input  logic signed [msp_pkg::SPEED_W-1:0]     target_speed_q8,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [msp_pkg::SPEED_W-1:0]     measured_speed_q8,
  output logic signed [msp_pkg::CMD_W-1:0]       drive_command,
  output logic        [msp_pkg::LEVEL_W-1:0]     drive_level,
  output logic                                   drive_forward,
  output logic                                   drive_reverse
);

  import msp_pkg::*;

  // Derived widths.
  localparam int MAG_PROD_W = COUNT_W + RPM_W;
  localparam int NUM_W      = MAG_PROD_W + SPEED_FRAC_BITS;
  localparam int DEN_W      = ELAPSED_W + CPR_W;
  localparam int SC_W       = (SUM_WIDTH > CAP_SHIFT + 2) ? CAP_SHIFT + 2 : SUM_WIDTH;
  localparam int MB_W       = (SC_W > COUNT_W + 1) ? SC_W : COUNT_W + 1;
  localparam int PROD_W     = MB_W + GAIN_W + 1;
  localparam int ACC_W      = PROD_W + 2;
  localparam int SUMX_W     = SUM_WIDTH + 1;
  localparam int CMPW       = (SUM_WIDTH > CAP_SHIFT + 2) ? SUM_WIDTH : CAP_SHIFT + 2;
  localparam int CMD_SHIFT  = GAIN_FRAC + SPEED_FRAC_BITS;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [CMPW-1:0] SC_CAP =
    {{(CMPW-CAP_SHIFT-1){1'b0}}, 1'b1, {CAP_SHIFT{1'b0}}};
  localparam logic signed [CMPW-1:0] SC_CAP_NEG = -SC_CAP;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

  // Configuration registers.
  logic [CPR_W-1:0]   enc_cpr;
  logic [LIMIT_W-1:0] speed_limit;
  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_d;

  // Control and loop state.
  state_t                       state;
  logic        [COUNT_W-1:0]    last_count;
  logic signed [SPEED_W-1:0]    speed_est;
  logic signed [SUM_WIDTH-1:0]  error_sum;
  logic signed [ERR_W-1:0]      last_error;
  logic        [1:0]            dir;

  // Working registers of one tick.
  logic        [COUNT_W-1:0]    count_mag;
  logic                         count_neg;
  logic        [ELAPSED_W-1:0]  elapsed;
  logic signed [SPEED_W-1:0]    target;
  logic        [DEN_W-1:0]      den;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ERR_W-1:0]      err;
  logic signed [DERR_W-1:0]     derr;
  logic signed [SC_W-1:0]       sc;

  // Output registers.
  logic signed [SPEED_W-1:0]    speed_out;
  logic signed [CMD_W-1:0]      cmd_out;
  logic        [LEVEL_W-1:0]    level_out;

  assign in_ready          = (state == S_IDLE);
  assign measured_speed_q8 = speed_out;
  assign drive_command     = cmd_out;
  assign drive_level       = level_out;
  assign drive_forward     = dir[0];
  assign drive_reverse     = dir[1];

  // Encoder difference since the previous tick, split into sign and magnitude.
  logic [COUNT_W-1:0] delta;
  logic [COUNT_W-1:0] delta_mag;
  always_comb begin
    delta     = encoder_count - last_count;
    delta_mag = delta[COUNT_W-1] ? (COUNT_W'(0) - delta) : delta;
  end

  // Shared multiplier: unsigned 16-bit operand times signed operand, registered.
  logic        [CPR_W-1:0]  cpr_eff;
  logic        [GAIN_W-1:0] mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_next;
  always_comb begin
    cpr_eff = (enc_cpr == '0) ? CPR_W'(1) : enc_cpr;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state)
      S_MUL_DEN: begin
        mul_a = elapsed;
        mul_b = MB_W'(cpr_eff);
      end
      S_MUL_MAG: begin
        mul_a = RPM_SCALE;
        mul_b = MB_W'(count_mag);
      end
      S_MUL_P: begin
        mul_a = gain_p;
        mul_b = MB_W'(err);
      end
      S_MUL_I: begin
        mul_a = gain_i;
        mul_b = MB_W'(sc);
      end
      S_MUL_D: begin
        mul_a = gain_d;
        mul_b = MB_W'(derr);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_next = PROD_W'($signed({1'b0, mul_a})) * PROD_W'(mul_b);
  end

  // Speed divider.
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_numer;
  logic [NUM_W-1:0] quot;

  assign div_start = (state == S_DIV_START);
  assign div_numer = NUM_W'(prod[MAG_PROD_W-1:0]) << SPEED_FRAC_BITS;

  msp_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (den),
    .done  (div_done),
    .quot  (quot)
  );

  // Signed, saturated speed from the quotient magnitude.
  logic                      q_high;
  logic [SPEED_W-1:0]        q_neg;
  logic signed [SPEED_W-1:0] speed_next;
  always_comb begin
    q_high = |quot[NUM_W-1:SPEED_W];
    q_neg  = SPEED_W'(0) - quot[SPEED_W-1:0];
    if (count_neg) begin
      if (q_high || (quot[SPEED_W-1] && (|quot[SPEED_W-2:0]))) begin
        speed_next = SPEED_MIN;
      end else begin
        speed_next = $signed(q_neg);
      end
    end else begin
      if (q_high || quot[SPEED_W-1]) begin
        speed_next = SPEED_MAX;
      end else begin
        speed_next = $signed(quot[SPEED_W-1:0]);
      end
    end
  end

  // Target clamp and error terms.
  logic signed [ERR_W-1:0]  lim;
  logic signed [ERR_W-1:0]  tgt;
  logic signed [ERR_W-1:0]  tgt_clamped;
  logic signed [ERR_W-1:0]  err_next;
  logic signed [DERR_W-1:0] derr_next;
  always_comb begin
    lim = $signed(ERR_W'(speed_limit));
    tgt = ERR_W'(target);
    priority if (tgt > lim) begin
      tgt_clamped = lim;
    end else if (tgt < -lim) begin
      tgt_clamped = -lim;
    end else begin
      tgt_clamped = tgt;
    end
    err_next  = tgt_clamped - ERR_W'(speed_est);
    derr_next = DERR_W'(err_next) - DERR_W'(last_error);
  end

  // Saturating integral update, cleared on a zero error.
  logic signed [SUMX_W-1:0]    sum_add;
  logic signed [SUM_WIDTH-1:0] error_sum_next;
  always_comb begin
    sum_add = SUMX_W'(error_sum) + SUMX_W'(err);
    priority if (err == '0) begin
      error_sum_next = '0;
    end else if (sum_add[SUMX_W-1] != sum_add[SUMX_W-2]) begin
      error_sum_next = sum_add[SUMX_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      error_sum_next = sum_add[SUM_WIDTH-1:0];
    end
  end

  // Integral term clamped to +/-2^45 ahead of the multiply.
  logic signed [CMPW-1:0] sum_wide;
  logic signed [SC_W-1:0] sc_next;
  always_comb begin
    sum_wide = CMPW'(error_sum);
    priority if (sum_wide > SC_CAP) begin
      sc_next = SC_W'(SC_CAP);
    end else if (sum_wide < SC_CAP_NEG) begin
      sc_next = SC_W'(SC_CAP_NEG);
    end else begin
      sc_next = SC_W'(error_sum);
    end
  end

  // Command: scale down, truncate toward zero and saturate to the PWM range.
  logic                      acc_neg;
  logic [ACC_W-1:0]          acc_mag;
  logic [ACC_W-1:0]          acc_shifted;
  logic [LEVEL_W-1:0]        level_next;
  logic signed [CMD_W-1:0]   cmd_next;
  always_comb begin
    acc_neg     = acc[ACC_W-1];
    acc_mag     = acc_neg ? (ACC_W'(0) - acc) : acc;
    acc_shifted = acc_mag >> CMD_SHIFT;
    level_next  = (|acc_shifted[ACC_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}}
                                                   : acc_shifted[LEVEL_W-1:0];
    cmd_next    = acc_neg ? $signed(CMD_W'(0) - {1'b0, level_next})
                          : $signed({1'b0, level_next});
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // Sequencer, configuration and loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      enc_cpr        <= CPR_W'(1);
      speed_limit    <= '0;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      last_count     <= '0;
      speed_est      <= '0;
      error_sum      <= '0;
      last_error     <= '0;
      dir            <= 2'b00;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ENC_CPR:        enc_cpr        <= cfg_data[CPR_W-1:0];
          REG_SPEED_LIMIT:    speed_limit    <= cfg_data[LIMIT_W-1:0];
          REG_GAIN_P:         gain_p         <= cfg_data[GAIN_W-1:0];
          REG_GAIN_I:         gain_i         <= cfg_data[GAIN_W-1:0];
          REG_GAIN_D:         gain_d         <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      // A new result loads the output register; otherwise an accepted one leaves it.
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_count <= encoder_count;
            state      <= (elapsed_ms != '0) ? S_MUL_DEN : S_ERR;
          end
        end
        S_MUL_DEN:   state <= S_MUL_MAG;
        S_MUL_MAG:   state <= S_DIV_START;
        S_DIV_START: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            speed_est <= speed_next;
            state     <= S_ERR;
          end
        end
        S_ERR: begin
          last_error <= err_next;
          state      <= S_SUM;
        end
        S_SUM: begin
          error_sum <= error_sum_next;
          state     <= S_MUL_P;
        end
        S_MUL_P: state <= S_MUL_I;
        S_MUL_I: state <= S_MUL_D;
        S_MUL_D: state <= S_ACC;
        S_ACC:   state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            if (level_next != '0) begin
              dir <= acc_neg ? 2'b10 : 2'b01;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working and output registers of the datapath.
  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (state == S_IDLE && in_valid) begin
      count_mag <= delta_mag;
      count_neg <= delta[COUNT_W-1];
      elapsed   <= elapsed_ms;
      target    <= target_speed_q8;
    end
    if (state == S_MUL_MAG) begin
      den <= prod[DEN_W-1:0];
    end
    if (state == S_ERR) begin
      err  <= err_next;
      derr <= derr_next;
    end
    if (state == S_MUL_P) begin
      sc <= sc_next;
    end
    if (state == S_MUL_I) begin
      acc <= ACC_W'(prod);
    end
    if (state == S_MUL_D || state == S_ACC) begin
      acc <= acc + ACC_W'(prod);
    end
    if (state == S_OUT && out_free) begin
      speed_out <= speed_est;
      cmd_out   <= cmd_next;
      level_out <= level_next;
    end
  end

endmodule

`default_nettype wire

### tb/sv/motor_speed_pid_controller_core_test.sv
// Self-checking testbench for the motor speed PID controller core.
`timescale 1ns / 1ps

module motor_speed_pid_controller_core_test;
  import msp_pkg::*;

  localparam int SPEED_FRAC    = 8;
  localparam int SUM_BITS      = 40;
  localparam int NUM_REGS      = 5;
  localparam int SETTLE_CYCLES = 80;        // longer than the slowest tick
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int PHASE_TICKS   = 305;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [CMD_W-1:0]   command;
    logic [LEVEL_W-1:0] level;
    logic               forward;
    logic               reverse;
  } drive_result_t;

  typedef enum {READY_ALWAYS, READY_LIGHT, READY_HEAVY} ready_pattern_t;
  typedef enum {MIX_TYPICAL, MIX_MAXIMUM, MIX_WIDE, MIX_RANDOM} config_mix_t;

  logic                        clk             = 1'b0;
  logic                        rst             = 1'b1;
  logic                        cfg_write       = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index       = '0;
  logic [CFG_DATA_W-1:0]       cfg_data        = '0;
  logic                        in_valid        = 1'b0;
  logic                        in_ready;
  logic signed [COUNT_W-1:0]   encoder_count   = '0;
  logic [ELAPSED_W-1:0]        elapsed_ms      = '0;
  logic signed [SPEED_W-1:0]   target_speed_q8 = '0;
  logic                        out_valid;
  logic                        out_ready       = 1'b0;
  logic signed [SPEED_W-1:0]   measured_speed_q8;
  logic signed [CMD_W-1:0]     drive_command;
  logic [LEVEL_W-1:0]          drive_level;
  logic                        drive_forward;
  logic                        drive_reverse;

  // Shadow copy of the configuration and of the controller state.
  longint unsigned     cpr_reg    = 1;
  longint              limit_reg  = 0;
  longint              kp_reg     = 0;
  longint              ki_reg     = 0;
  longint              kd_reg     = 0;
  logic [COUNT_W-1:0]  prev_count = '0;
  longint              speed_est  = 0;
  longint              err_sum    = 0;
  longint              prev_err   = 0;
  logic                dir_fwd    = 1'b0;
  logic                dir_rev    = 1'b0;

  drive_result_t       pending_results[$];
  drive_result_t       want;
  int                  error_count  = 0;
  int                  result_index = 0;
  int unsigned         cycle_count  = 0;

  // Sender and receiver pacing state.
  int                  burst_left  = 0;
  ready_pattern_t      ready_mode  = READY_ALWAYS;
  int                  ready_hold  = 0;
  logic [COUNT_W-1:0]  stim_count  = '0;
  logic [COUNT_W-1:0]  cruise_step = 32'd1;
  logic [ELAPSED_W-1:0] cruise_ms  = 16'd10;

  motor_speed_pid_controller_core #(
    .SPEED_FRAC_BITS(SPEED_FRAC),
    .SUM_WIDTH      (SUM_BITS)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .encoder_count    (encoder_count),
    .elapsed_ms       (elapsed_ms),
    .target_speed_q8  (target_speed_q8),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .measured_speed_q8(measured_speed_q8),
    .drive_command    (drive_command),
    .drive_level      (drive_level),
    .drive_forward    (drive_forward),
    .drive_reverse    (drive_reverse)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Works out one control tick: speed measurement, target clamp, PID and direction lines.
  function automatic drive_result_t predict_tick(input logic [COUNT_W-1:0] cnt,
                                                 input logic [ELAPSED_W-1:0] el,
                                                 input logic signed [SPEED_W-1:0] tgt);
    logic [COUNT_W-1:0] diff;
    longint             delta, target, err, capped, total, cmd, sum_max, sum_min, cap;
    longint unsigned    mag, quot, divisor;
    drive_result_t      r;
    diff  = cnt - prev_count;
    delta = longint'($signed(diff));
    if (el != 0) begin
      divisor = longint'(el) * (cpr_reg == 0 ? 64'd1 : cpr_reg);
      mag     = delta < 0 ? -delta : delta;
      quot    = ((mag * 64'd60000) << SPEED_FRAC) / divisor;
      if (delta < 0) begin
        speed_est = quot > 64'd8388608 ? -64'sd8388608 : -longint'(quot);
      end else begin
        speed_est = quot > 64'd8388607 ? 64'sd8388607 : longint'(quot);
      end
    end
    prev_count = cnt;

    target = tgt;
    if (target > limit_reg) target = limit_reg;
    if (target < -limit_reg) target = -limit_reg;
    err = target - speed_est;

    // The error sum saturates, and a zero error clears it.
    sum_max = (longint'(1) <<< (SUM_BITS - 1)) - 1;
    sum_min = -sum_max - 1;
    cap     = longint'(1) <<< CAP_SHIFT;
    if (err > 0 && err_sum > sum_max - err) err_sum = sum_max;
    else if (err < 0 && err_sum < sum_min - err) err_sum = sum_min;
    else err_sum = err_sum + err;
    if (err == 0) err_sum = 0;
    capped = err_sum > cap ? cap : (err_sum < -cap ? -cap : err_sum);

    total    = kp_reg * err + ki_reg * capped + kd_reg * (err - prev_err);
    prev_err = err;
    mag      = total < 0 ? -total : total;
    quot     = mag >> (GAIN_FRAC + SPEED_FRAC);
    if (quot > 64'd255) quot = 64'd255;
    cmd = total < 0 ? -longint'(quot) : longint'(quot);

    // Direction lines hold their levels on a zero command.
    if (cmd > 0) begin
      dir_fwd = 1'b1;
      dir_rev = 1'b0;
    end else if (cmd < 0) begin
      dir_fwd = 1'b0;
      dir_rev = 1'b1;
    end

    r.speed   = speed_est[SPEED_W-1:0];
    r.command = cmd[CMD_W-1:0];
    r.level   = quot[LEVEL_W-1:0];
    r.forward = dir_fwd;
    r.reverse = dir_rev;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string field_name, input longint got, input longint want_v);
    if (got != want_v) begin
      report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                result_index, field_name, got, want_v));
    end
  endtask

  // Compares each delivered result with the oldest predicted one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no tick waiting", result_index));
      end else begin
        want = pending_results.pop_front();
        check_field("measured_speed_q8", longint'(measured_speed_q8),
                    longint'($signed(want.speed)));
        check_field("drive_command", longint'(drive_command), longint'($signed(want.command)));
        check_field("drive_level", longint'(drive_level), longint'(want.level));
        check_field("drive_forward", longint'(drive_forward), longint'(want.forward));
        check_field("drive_reverse", longint'(drive_reverse), longint'(want.reverse));
      end
      result_index++;
    end
  end

  // The receiver switches between randomly chosen stall patterns after a random hold.
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = ready_pattern_t'($urandom_range(0, 2));
      ready_hold = $urandom_range(40, 300);
    end else begin
      ready_hold--;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_LIGHT:  out_ready <= ($urandom_range(0, 3) != 0);
      default:      out_ready <= ($urandom_range(0, 7) > 4);
    endcase
  end

  // Sends one tick, pausing between bursts, and records its prediction once accepted.
  task automatic send_tick(input logic [COUNT_W-1:0] cnt, input logic [ELAPSED_W-1:0] el,
                           input logic signed [SPEED_W-1:0] tgt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    encoder_count   <= cnt;
    elapsed_ms      <= el;
    target_speed_q8 <= tgt;
    stim_count = cnt;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_tick(cnt, el, tgt));
    @(negedge clk);
  endtask

  // Stops sending and lets every outstanding tick finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_ENC_CPR:        cpr_reg   = data[CPR_W-1:0];
      REG_SPEED_LIMIT:    limit_reg = data[LIMIT_W-1:0];
      REG_GAIN_P:         kp_reg    = data[GAIN_W-1:0];
      REG_GAIN_I:         ki_reg    = data[GAIN_W-1:0];
      REG_GAIN_D:         kd_reg    = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Writes every register; the unused upper data bits of 16-bit registers carry noise.
  task automatic write_all(input logic [CPR_W-1:0] cpr, input logic [LIMIT_W-1:0] limit,
                           input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                           input logic [GAIN_W-1:0] kd);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data[CPR_W-1:0] = cpr;
    write_reg(REG_ENC_CPR, data);
    write_reg(REG_SPEED_LIMIT, limit);
    data = CFG_DATA_W'($urandom);
    data[GAIN_W-1:0] = kp;
    write_reg(REG_GAIN_P, data);
    data = CFG_DATA_W'($urandom);
    data[GAIN_W-1:0] = ki;
    write_reg(REG_GAIN_I, data);
    data = CFG_DATA_W'($urandom);
    data[GAIN_W-1:0] = kd;
    write_reg(REG_GAIN_D, data);
  endtask

  // Register defaults: the target clamps to zero and the command stays zero.
  task automatic test_reset_state();
    send_tick(32'd0, 16'd0, 24'sh7FFFFF);
    send_tick(32'd1, 16'd1, 24'sh800000);   // one count in one ms saturates high
    send_tick(32'd0, 16'd1, 24'sd0);        // and one count back saturates low
  endtask

  // Speed measurement at the edges of the count, interval and scale ranges.
  task automatic test_speed_measurement();
    wait_idle();
    write_reg(REG_ENC_CPR, 23'd65535);
    send_tick(32'h7FFF_FFFF, 16'hFFFF, 24'sd0);   // largest forward step, longest interval
    send_tick(32'h8000_0000, 16'hFFFF, 24'sd0);   // count wraps by one, speed rounds to zero
    send_tick(32'h7FFF_FFFF, 16'd0, 24'sd0);      // zero interval keeps the old speed
    send_tick(32'h7FFF_FF00, 16'd1, 24'sd0);      // reverse speed truncates toward zero
    wait_idle();
    write_reg(REG_ENC_CPR, 23'd0);                // zero counts per rev acts as one
    send_tick(32'h7FFF_FEFF, 16'hFFFF, 24'sd0);
    send_tick(32'hFFFF_FEFF, 16'hFFFF, 24'sd0);   // step of -2^31 saturates low
  endtask

  // PID behavior: target clamping, zero error, held direction and command saturation.
  task automatic test_pid_directed();
    wait_idle();
    write_all(16'd100, 23'd25600, 16'd256, 16'd16, 16'd64);
    send_tick(stim_count + 32'd1, 16'd10, 24'sh7FFFFF);
    send_tick(stim_count + 32'd1, 16'd10, 24'sh800000);
    send_tick(stim_count + 32'd1, 16'd10, 24'sd15360);   // error exactly zero
    send_tick(stim_count + 32'd1, 16'd10, 24'sd15360);   // zero command, direction holds
    send_tick(stim_count - 32'd5, 16'd10, 24'sd25600);   // command saturates high
    send_tick(stim_count + 32'd40, 16'd10, 24'sh800000); // command saturates low
    send_tick(stim_count + 32'd9, 16'd0, 24'sd0);        // zero interval keeps the speed
  endtask

  // Largest and smallest settings, plus writes to indexes past the register list.
  task automatic test_config_extremes();
    wait_idle();
    write_all(16'hFFFF, 23'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    end
    send_tick(stim_count + 32'd1000, 16'd1, 24'sh7FFFFF);
    send_tick(stim_count - 32'd1000, 16'd1, 24'sh800000);
    send_tick(stim_count + 32'd3, 16'd7, 24'sd1234);
    wait_idle();
    write_all(16'd1, 23'd0, 16'd0, 16'd0, 16'd0);
    send_tick(stim_count + 32'd1, 16'd3, 24'sd99);
    send_tick(stim_count, 16'hFFFF, 24'sh800000);
  endtask

  // Mostly steady motion with targets near the measured speed, mixed with jumps and noise.
  task automatic random_tick();
    logic [COUNT_W-1:0]        count_step;
    logic [ELAPSED_W-1:0]      el;
    logic signed [SPEED_W-1:0] tgt;
    int                        pick;
    if ($urandom_range(0, 99) < 8) begin
      cruise_step = $urandom_range(0, 400) - 200;
      cruise_ms   = ELAPSED_W'($urandom_range(1, 40));
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      count_step = cruise_step;
      el         = cruise_ms;
    end else begin
      if (pick < 66) count_step = '0;
      else if (pick < 80) count_step = $urandom_range(0, 2000) - 1000;
      else if (pick < 92) count_step = $urandom_range(0, 200000) - 100000;
      else count_step = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 12) el = '0;
      else if (pick < 90) el = ELAPSED_W'($urandom_range(1, 60));
      else el = ELAPSED_W'($urandom_range(0, 65535));
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) tgt = SPEED_W'(speed_est + longint'($urandom_range(0, 8)) - 4);
    else if (pick < 80) tgt = SPEED_W'($urandom_range(0, 262144) - 131072);
    else tgt = SPEED_W'($urandom);
    send_tick(stim_count + count_step, el, tgt);
  endtask

  // One random phase: a fresh configuration followed by a run of random ticks.
  task automatic test_random_ticks(input config_mix_t mix, input int n);
    wait_idle();
    case (mix)
      MIX_TYPICAL: write_all(CPR_W'($urandom_range(50, 2000)),
                             LIMIT_W'($urandom_range(0, 1 << 20)),
                             GAIN_W'($urandom_range(0, 1024)), GAIN_W'($urandom_range(0, 64)),
                             GAIN_W'($urandom_range(0, 512)));
      MIX_MAXIMUM: write_all(16'hFFFF, 23'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      MIX_WIDE:    write_all(16'd0, LIMIT_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                             GAIN_W'($urandom));
      default:     write_all(CPR_W'($urandom_range(0, 1) ? $urandom : $urandom_range(1, 300)),
                             LIMIT_W'($urandom_range(0, 1) ? $urandom
                                                            : $urandom_range(0, 1 << 18)),
                             GAIN_W'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 600)),
                             GAIN_W'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 40)),
                             GAIN_W'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 600)));
    endcase
    repeat (n) random_tick();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_speed_measurement();
    test_pid_directed();
    test_config_extremes();
    test_random_ticks(MIX_TYPICAL, PHASE_TICKS);
    test_random_ticks(MIX_MAXIMUM, PHASE_TICKS);
    test_random_ticks(MIX_WIDE, PHASE_TICKS);
    test_random_ticks(MIX_RANDOM, PHASE_TICKS);
    test_random_ticks(MIX_RANDOM, PHASE_TICKS);
    test_random_ticks(MIX_RANDOM, PHASE_TICKS);
    wait_idle();
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d ticks never produced a result", pending_results.size()));
    end
    if (error_count == 0) begin
      $display("motor_speed_pid_controller_core_test OK");
    end else begin
      $display("motor_speed_pid_controller_core_test NOT OK");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("motor_speed_pid_controller_core_test NOT OK");
    $finish;
  end

endmodule
